// File: sv/rbst_pkg.sv
package rbst_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_BOX_MIN_X = 3'd0;
	localparam cfg_idx_t REG_BOX_MAX_X = 3'd1;
	localparam cfg_idx_t REG_BOX_MIN_Y = 3'd2;
	localparam cfg_idx_t REG_BOX_MAX_Y = 3'd3;
	localparam cfg_idx_t REG_BOX_MIN_Z = 3'd4;
	localparam cfg_idx_t REG_BOX_MAX_Z = 3'd5;
	localparam cfg_idx_t REG_HIT_EPS   = 3'd6;

	localparam int NUM_AXES = 3;
	localparam int EPS_W    = 16;

	// per-axis flags carried alongside the divider pipeline
	typedef struct packed {
		logic zero;    // direction component is zero
		logic in_slab; // origin strictly inside the slab
		logic dneg;    // direction component is negative
	} axis_flags_t;

endpackage

// File: sv/rbst_ray_if.sv
interface rbst_ray_if #(
	parameter int W = 32
);
	logic valid;
	logic ready;
	logic signed [W-1:0] origin_x;
	logic signed [W-1:0] origin_y;
	logic signed [W-1:0] origin_z;
	logic signed [W-1:0] dir_x;
	logic signed [W-1:0] dir_y;
	logic signed [W-1:0] dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

// File: sv/rbst_hit_if.sv
interface rbst_hit_if;
	logic valid;
	logic ready;
	logic is_hit;

	modport source (output valid, is_hit, input ready);
	modport sink (input valid, is_hit, output ready);
endinterface

// File: sv/ray_box_slab_test_unit.sv
// Ray versus axis-aligned box slab test.
// ray_in carries one ray per transfer: origin and direction, signed fixed
// point with FRAC_BITS fraction bits in COORD_WIDTH bits. hit_out returns one
// is_hit bit per ray, in order. Box bounds and hit epsilon are set through the
// write port (cfg_we, cfg_idx, cfg_data). The user must write them only while
// no ray is in flight; the block itself does not enforce this. The pipeline
// holds the slab subtractions, the six parallel dividers that make one
// quotient bit per iteration stage, entry/exit selection with min/max, and
// the final compare into the output register.
// Throughput is one ray per cycle while hit_out is not stalled. Each stage
// advances when it is empty or the stage after it advances, so bubbles close up
// while hit_out is stalled and ray_in stays ready until every stage holds a ray.
// Reset clears all valid bits and loads the box to [-1.0, +1.0] on each axis
// and epsilon to 0.001 rounded. A stall on hit_out holds the result and
// backs the pipeline up without losing or repeating a ray.
module ray_box_slab_test_unit #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  rbst_pkg::cfg_idx_t       cfg_idx,
	input  logic [COORD_WIDTH-1:0]   cfg_data,
	rbst_ray_if.sink                 ray_in,
	rbst_hit_if.source               hit_out
);
	import rbst_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int P = W + 5;          // total stages
	localparam int SEL = W + 3;        // min/max stage
	localparam logic signed [W-1:0] ONE    = W'(1) << F;
	localparam logic signed [W-1:0] LIM    = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] NLIM   = -LIM;
	localparam logic [EPS_W-1:0]    EPS_RST = EPS_W'(((2 ** F) + 500) / 1000);

	// configuration registers
	logic signed [W-1:0] box_min_q [NUM_AXES];
	logic signed [W-1:0] box_max_q [NUM_AXES];
	logic [EPS_W-1:0]    eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				box_min_q[a] <= -ONE;
				box_max_q[a] <= ONE;
			end
			eps_q <= EPS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BOX_MIN_X: box_min_q[0] <= cfg_data;
				REG_BOX_MAX_X: box_max_q[0] <= cfg_data;
				REG_BOX_MIN_Y: box_min_q[1] <= cfg_data;
				REG_BOX_MAX_Y: box_max_q[1] <= cfg_data;
				REG_BOX_MIN_Z: box_min_q[2] <= cfg_data;
				REG_BOX_MAX_Z: box_max_q[2] <= cfg_data;
				REG_HIT_EPS:   eps_q <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage valids and advance enables
	logic [P-1:0] v_q;
	logic [P-1:0] en;

	always_comb begin
		en[P-1] = !v_q[P-1] || hit_out.ready;
		for (int k = P - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= ray_in.valid;
			end
			for (int k = 1; k < P; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign ray_in.ready  = en[0];

	// stage 1: slab numerators and axis flags
	logic signed [W-1:0] org [NUM_AXES];
	logic signed [W-1:0] dir [NUM_AXES];
	logic signed [W:0]   num_lo_s1 [NUM_AXES];
	logic signed [W:0]   num_hi_s1 [NUM_AXES];
	logic signed [W-1:0] den_s1    [NUM_AXES];
	axis_flags_t         flags_s   [SEL][NUM_AXES];

	assign org[0] = ray_in.origin_x;
	assign org[1] = ray_in.origin_y;
	assign org[2] = ray_in.origin_z;
	assign dir[0] = ray_in.dir_x;
	assign dir[1] = ray_in.dir_y;
	assign dir[2] = ray_in.dir_z;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				num_lo_s1[a] <= (W+1)'(box_min_q[a]) - (W+1)'(org[a]);
				num_hi_s1[a] <= (W+1)'(box_max_q[a]) - (W+1)'(org[a]);
				den_s1[a]    <= dir[a];
				flags_s[0][a].zero    <= dir[a] == '0;
				flags_s[0][a].in_slab <= (org[a] > box_min_q[a]) && (org[a] < box_max_q[a]);
				flags_s[0][a].dneg    <= dir[a][W-1];
			end
		end
	end

	// flags ride along with the dividers
	always_ff @(posedge clk) begin
		for (int k = 1; k < SEL; k++) begin
			if (en[k]) begin
				flags_s[k] <= flags_s[k-1];
			end
		end
	end

	// six dividers, stages 2 .. W+3
	logic signed [W-1:0] t_lo [NUM_AXES];
	logic signed [W-1:0] t_hi [NUM_AXES];

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		rbst_div #(.W(W), .F(F)) u_div_lo (
			.clk (clk),
			.en  (en[SEL-1:1]),
			.num (num_lo_s1[a]),
			.den (den_s1[a]),
			.quo (t_lo[a])
		);
		rbst_div #(.W(W), .F(F)) u_div_hi (
			.clk (clk),
			.en  (en[SEL-1:1]),
			.num (num_hi_s1[a]),
			.den (den_s1[a]),
			.quo (t_hi[a])
		);
	end

	// entry/exit per axis, then latest entry and earliest exit
	logic signed [W-1:0] t_in  [NUM_AXES];
	logic signed [W-1:0] t_out [NUM_AXES];
	logic signed [W-1:0] t0_c, t1_c;
	logic                ok_c;
	logic signed [W-1:0] t0_s2, t1_s2;
	logic                ok_s2;

	always_comb begin
		ok_c = 1'b1;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (flags_s[SEL-1][a].zero) begin
				t_in[a]  = NLIM;
				t_out[a] = LIM;
				ok_c     = ok_c && flags_s[SEL-1][a].in_slab;
			end else begin
				t_in[a]  = flags_s[SEL-1][a].dneg ? t_hi[a] : t_lo[a];
				t_out[a] = flags_s[SEL-1][a].dneg ? t_lo[a] : t_hi[a];
			end
		end
		t0_c = (t_in[0] > t_in[1]) ? t_in[0] : t_in[1];
		if (t_in[2] > t0_c) t0_c = t_in[2];
		t1_c = (t_out[0] < t_out[1]) ? t_out[0] : t_out[1];
		if (t_out[2] < t1_c) t1_c = t_out[2];
	end

	always_ff @(posedge clk) begin
		if (en[SEL]) begin
			t0_s2 <= t0_c;
			t1_s2 <= t1_c;
			ok_s2 <= ok_c;
		end
	end

	// final compare into the output register
	logic hit_q;

	always_ff @(posedge clk) begin
		if (en[P-1]) begin
			hit_q <= ok_s2 && (t0_s2 < t1_s2) &&
				($signed({t1_s2[W-1], t1_s2}) > $signed({1'b0, (W)'(eps_q)}));
		end
	end

	assign hit_out.valid  = v_q[P-1];
	assign hit_out.is_hit = hit_q;

	// an empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!hit_out.valid |-> ray_in.ready)
		else $error("input not ready with empty output stage");

	// an accepted ray lands in the first stage
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(ray_in.valid && ray_in.ready) |=> v_q[0])
		else $error("accepted ray lost at the first stage");

	// a blocked zero-direction axis forces a miss
	a_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[P-2] && en[P-1] && !ok_s2) |=> !hit_out.is_hit)
		else $error("hit reported for a blocked axis");
endmodule

// File: sv/rbst_div.sv
// Pipelined signed fractional divider: quo = num * 2^F / den, truncated toward
// zero, magnitude saturated at 2^(W-1)-1. One quotient bit per stage.
// Stage 0 prepares magnitudes, stages 1..W iterate, stage W+1 applies sign.
module rbst_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic [W+1:0]        en,
	input  logic signed [W:0]   num,
	input  logic signed [W-1:0] den,
	output logic signed [W-1:0] quo
);
	localparam logic [W-1:0] LIM = {1'b0, {(W-1){1'b1}}};

	logic [W:0]   mag_n;
	logic [W-1:0] mag_d;
	logic [W:0]   hi;
	logic         ovf;

	logic [W-1:0] rem_s [W+1];
	logic [W-1:0] nb_s  [W+1];
	logic [W-1:0] q_s   [W+1];
	logic [W-1:0] d_s   [W+1];
	logic         neg_s [W+1];
	logic         ovf_s [W+1];

	logic [W-1:0] mag_fin;

	// magnitudes and overflow check on the quotient bits from W upward
	always_comb begin
		mag_n = num[W] ? (W+1)'(-num) : (W+1)'(num);
		mag_d = den[W-1] ? W'(-den) : W'(den);
		hi    = mag_n >> (W - F);
		ovf   = hi >= {1'b0, mag_d};
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= ovf ? '0 : hi[W-1:0];
			nb_s[0]  <= {mag_n[W-F-1:0], {F{1'b0}}};
			q_s[0]   <= '0;
			d_s[0]   <= mag_d;
			neg_s[0] <= num[W] ^ den[W-1];
			ovf_s[0] <= ovf;
		end
	end

	// restoring iterations
	for (genvar i = 0; i < W; i++) begin : g_iter
		logic [W:0] trial;
		logic       ge;
		always_comb begin
			trial = {rem_s[i], nb_s[i][W-1]};
			ge    = trial >= {1'b0, d_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				rem_s[i+1] <= ge ? W'(trial - {1'b0, d_s[i]}) : trial[W-1:0];
				nb_s[i+1]  <= {nb_s[i][W-2:0], 1'b0};
				q_s[i+1]   <= {q_s[i][W-2:0], ge};
				d_s[i+1]   <= d_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	// saturate and restore sign
	assign mag_fin = (ovf_s[W] || q_s[W][W-1]) ? LIM : q_s[W];

	always_ff @(posedge clk) begin
		if (en[W+1]) begin
			quo <= neg_s[W] ? -$signed(mag_fin) : $signed(mag_fin);
		end
	end
endmodule
